// ===== rtl/swmc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swmc_pkg: shared types and constants of the sliding-window median cost block
// Sizes of the sorted cell row, sample and sum widths, cell operation codes.
// ----------------------------------------------------------------------------
package swmc_pkg;

  localparam int NumCells = 256;
  localparam int SampleW  = 32;
  localparam int CountW   = 9;
  localparam int IdxW     = 8;
  localparam int SumW     = 41;
  localparam int CostW    = 40;
  localparam int WideW    = 43;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [1:0] cell_op_t;

  localparam cell_op_t OP_HOLD = 2'd0;
  localparam cell_op_t OP_CLR  = 2'd1;
  localparam cell_op_t OP_REM  = 2'd2;
  localparam cell_op_t OP_INS  = 2'd3;

  typedef struct packed {
    cell_op_t op;
    sample_t  rem_val;
    sample_t  ins_val;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/swmc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swmc_cell: one entry of the sorted window
// Holds a value and a valid bit; removes by shifting left, inserts by
// shifting right, taking the neighbour's value or the new sample.
// ----------------------------------------------------------------------------
module swmc_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swmc_pkg::cell_ctrl_t  ctrl_i,
  input  swmc_pkg::sample_t     left_val_i,
  input  logic                  left_valid_i,
  input  logic                  left_le_i,
  input  swmc_pkg::sample_t     right_val_i,
  input  logic                  right_valid_i,
  output swmc_pkg::sample_t     val_o,
  output logic                  valid_o,
  output logic                  le_o
);

  swmc_pkg::sample_t val_q, val_d;
  logic              valid_q, valid_d;

  assign le_o    = valid_q && (val_q <= ctrl_i.ins_val);
  assign val_o   = val_q;
  assign valid_o = valid_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    case (ctrl_i.op)
      swmc_pkg::OP_CLR: begin
        valid_d = 1'b0;
      end
      swmc_pkg::OP_REM: begin
        if (!valid_q || (val_q >= ctrl_i.rem_val)) begin
          val_d = right_val_i;
        end
        valid_d = right_valid_i;
      end
      swmc_pkg::OP_INS: begin
        if (!le_o) begin
          val_d = left_le_i ? ctrl_i.ins_val : left_val_i;
        end
        valid_d = left_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/swmc_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swmc_chain: row of sorted-window cells
// Cell 0 holds the smallest value; valid cells form a prefix of the row.
// ----------------------------------------------------------------------------
module swmc_chain (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swmc_pkg::cell_ctrl_t  ctrl_i,
  output swmc_pkg::sample_t     val_o [swmc_pkg::NumCells]
);

  logic valid [swmc_pkg::NumCells];
  logic le    [swmc_pkg::NumCells];

  for (genvar i = 0; i < swmc_pkg::NumCells; i++) begin : g_cell
    swmc_pkg::sample_t left_val, right_val;
    logic              left_valid, left_le, right_valid;

    if (i == 0) begin : g_first
      assign left_val   = ctrl_i.ins_val;
      assign left_valid = 1'b1;
      assign left_le    = 1'b1;
    end else begin : g_mid_l
      assign left_val   = val_o[i-1];
      assign left_valid = valid[i-1];
      assign left_le    = le[i-1];
    end

    if (i == swmc_pkg::NumCells - 1) begin : g_last
      assign right_val   = val_o[i];
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_val   = val_o[i+1];
      assign right_valid = valid[i+1];
    end

    swmc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .left_val_i   (left_val),
      .left_valid_i (left_valid),
      .left_le_i    (left_le),
      .right_val_i  (right_val),
      .right_valid_i(right_valid),
      .val_o        (val_o[i]),
      .valid_o      (valid[i]),
      .le_o         (le[i])
    );
  end

endmodule
`default_nettype wire

// ===== rtl/sliding_window_median_cost.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_cost: running lower median and absolute deviation sum
// Usage: samples enter on the s_axis stream (tdata = sample, tuser = first,
// which empties the window before the sample enters). The window size is set
// via cfg_we_i / cfg_wdata_i, by the user only while idle (not enforced); a write
// also empties the window. Once the window holds window_size samples, each item
// yields one result on m_axis: tdata[31:0] = lower median, tdata[71:32] = cost.
// Timing: an item is accepted, then the oldest sample is removed from the sorted
// cell row, then the new sample is inserted; the result is registered in the next
// idle cycle in which the output is free, when the next item may already be
// accepted. The sorted row does one shift per cycle, one item at a time.
// Reset: window empty, window_size 1, no result pending.
// Stall: a held result stays on m_axis; one further result may wait inside,
// after which s_axis_tready stays low until the output drains.
// ----------------------------------------------------------------------------
module sliding_window_median_cost (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swmc_pkg::CountW-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // sample
  input  logic                          s_axis_tuser,  // first
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata   // median, cost
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_REM  = 2'd1;
  localparam logic [1:0] ST_INS  = 2'd2;

  localparam logic [swmc_pkg::CountW-1:0] MaxFill = swmc_pkg::CountW'(swmc_pkg::NumCells);
  localparam logic [swmc_pkg::CostW-1:0]  CostMax = '1;

  logic [1:0]                       state_q, state_d;
  logic [swmc_pkg::CountW-1:0]      ksize_q, ksize_d;
  logic [swmc_pkg::CountW-1:0]      fill_q, fill_d;
  logic [swmc_pkg::IdxW-1:0]        ptr_q, ptr_d;
  logic signed [swmc_pkg::SumW-1:0] lsum_q, lsum_d;
  logic signed [swmc_pkg::SumW-1:0] tsum_q, tsum_d;
  logic                             pend_q, pend_d;
  logic                             ovalid_q, ovalid_d;
  swmc_pkg::sample_t                smp_q;
  logic                             first_q;
  swmc_pkg::sample_t                old_q;
  swmc_pkg::sample_t                med_q;
  logic [swmc_pkg::CostW-1:0]       cost_q;

  swmc_pkg::sample_t                ring_q [swmc_pkg::NumCells];
  swmc_pkg::sample_t                cells  [swmc_pkg::NumCells];
  swmc_pkg::cell_ctrl_t             ctrl;

  logic                             accept, load, out_free, do_rem, ring_we;
  logic [swmc_pkg::IdxW-1:0]        rd_addr, ptr_eff, sel_idx;
  logic [swmc_pkg::CountW-1:0]      fill_m1;
  swmc_pkg::sample_t                sel_val;
  logic signed [swmc_pkg::SumW-1:0] x_w, r_w, s_w;
  logic signed [swmc_pkg::WideW-1:0] cost_w;

  assign out_free      = !ovalid_q || m_axis_tready;
  assign load          = (state_q == ST_IDLE) && pend_q && out_free;
  assign s_axis_tready = (state_q == ST_IDLE) && (!pend_q || out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {cost_q, med_q};

  // boundary entry of the sorted row: lower median when idle, half edge otherwise
  assign fill_m1 = fill_q - swmc_pkg::CountW'(1);
  assign sel_idx = (state_q == ST_IDLE) ? fill_m1[swmc_pkg::CountW-1:1]
                                        : fill_q[swmc_pkg::CountW-1:1];
  assign sel_val = cells[sel_idx];

  assign x_w = swmc_pkg::SumW'(sel_val);
  assign r_w = swmc_pkg::SumW'(old_q);
  assign s_w = swmc_pkg::SumW'(smp_q);

  assign rd_addr = ptr_q - fill_q[swmc_pkg::IdxW-1:0];
  assign ptr_eff = first_q ? '0 : ptr_q;
  assign do_rem  = !first_q && (fill_q >= ksize_q) && (fill_q != '0);
  assign ring_we = (state_q == ST_REM);

  assign cost_w = swmc_pkg::WideW'(tsum_q) - (swmc_pkg::WideW'(lsum_q) <<< 1)
                + (fill_q[0] ? swmc_pkg::WideW'(sel_val) : '0);

  always_comb begin
    ctrl.op      = swmc_pkg::OP_HOLD;
    ctrl.rem_val = old_q;
    ctrl.ins_val = smp_q;
    if (cfg_we_i) begin
      ctrl.op = swmc_pkg::OP_CLR;
    end else if (state_q == ST_REM) begin
      if (first_q) begin
        ctrl.op = swmc_pkg::OP_CLR;
      end else if (do_rem) begin
        ctrl.op = swmc_pkg::OP_REM;
      end
    end else if (state_q == ST_INS) begin
      ctrl.op = swmc_pkg::OP_INS;
    end
  end

  always_comb begin
    state_d  = state_q;
    ksize_d  = ksize_q;
    fill_d   = fill_q;
    ptr_d    = ptr_q;
    lsum_d   = lsum_q;
    tsum_d   = tsum_q;
    pend_d   = pend_q;
    ovalid_d = ovalid_q;

    if (load) begin
      ovalid_d = 1'b1;
      pend_d   = 1'b0;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_REM;
        end
      end
      ST_REM: begin
        state_d = ST_INS;
        ptr_d   = ptr_eff + swmc_pkg::IdxW'(1);
        if (first_q) begin
          fill_d = '0;
          lsum_d = '0;
          tsum_d = '0;
        end else if (do_rem) begin
          fill_d = fill_m1;
          tsum_d = tsum_q - r_w;
          if (!fill_q[0]) begin
            lsum_d = (x_w >= r_w) ? lsum_q - r_w + x_w : lsum_q;
          end else begin
            lsum_d = (x_w >= r_w) ? lsum_q - r_w : lsum_q - x_w;
          end
        end
      end
      ST_INS: begin
        state_d = ST_IDLE;
        fill_d  = fill_q + swmc_pkg::CountW'(1);
        tsum_d  = tsum_q + s_w;
        pend_d  = ((fill_q + swmc_pkg::CountW'(1)) == ksize_q);
        if (!fill_q[0]) begin
          lsum_d = ((fill_q == '0) || (x_w > s_w)) ? lsum_q + s_w : lsum_q + x_w;
        end else if (x_w > s_w) begin
          lsum_d = lsum_q + s_w - x_w;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        ksize_d = swmc_pkg::CountW'(1);
      end else if (cfg_wdata_i > MaxFill) begin
        ksize_d = MaxFill;
      end else begin
        ksize_d = cfg_wdata_i;
      end
      fill_d = '0;
      ptr_d  = '0;
      lsum_d = '0;
      tsum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ksize_q  <= swmc_pkg::CountW'(1);
      fill_q   <= '0;
      ptr_q    <= '0;
      lsum_q   <= '0;
      tsum_q   <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ksize_q  <= ksize_d;
      fill_q   <= fill_d;
      ptr_q    <= ptr_d;
      lsum_q   <= lsum_d;
      tsum_q   <= tsum_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q   <= s_axis_tdata;
      first_q <= s_axis_tuser;
    end
    if (load) begin
      med_q  <= sel_val;
      cost_q <= (cost_w[swmc_pkg::WideW-1:swmc_pkg::CostW] != '0)
                ? CostMax : cost_w[swmc_pkg::CostW-1:0];
    end
  end

  // arrival ring: oldest entry read while idle, new sample written on removal step
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[ptr_eff] <= smp_q;
    end
    if (state_q == ST_IDLE) begin
      old_q <= ring_q[rd_addr];
    end
  end

  swmc_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .val_o (cells)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_sliding_window_median_cost.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_cost: self-checking bench for the median cost block
// Feeds signed samples on s_axis across a range of window sizes and checks
// every median and deviation sum on m_axis against a queue-based window
// kept in the bench, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_cost;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE      = 12;
  localparam logic [31:0] S_MIN       = 32'h8000_0000;
  localparam logic [31:0] S_MAX       = 32'h7fff_ffff;
  localparam logic [31:0] S_NEG1      = 32'hffff_ffff;

  typedef struct packed {
    logic [swmc_pkg::CostW-1:0] cost;
    logic [31:0]                median;
  } median_cost_t;

  typedef enum int {RX_READY, RX_COIN, RX_LONG, RX_PERIODIC} rx_pattern_e;

  class median_cost_scoreboard;
    int unsigned  span;
    longint       arrivals[$];
    longint       ordered[$];
    median_cost_t pending_results[$];
    int           errors;

    function new();
      span   = 1;
      errors = 0;
    endfunction

    function void set_window(logic [swmc_pkg::CountW-1:0] value);
      if (value == 0) span = 1;
      else if (value > swmc_pkg::NumCells) span = swmc_pkg::NumCells;
      else span = value;
      arrivals.delete();
      ordered.delete();
    endfunction

    function void take_sample(logic [31:0] raw, logic restart);
      longint       s;
      longint       oldest;
      longint       med;
      longint       acc;
      int           idx;
      int           low_n;
      median_cost_t res;
      s = longint'($signed(raw));
      if (restart) begin
        arrivals.delete();
        ordered.delete();
      end
      while (arrivals.size() >= span) begin
        oldest = arrivals.pop_front();
        idx = 0;
        while (idx < ordered.size() - 1 && ordered[idx] != oldest) idx++;
        ordered.delete(idx);
      end
      arrivals.push_back(s);
      idx = ordered.size();
      while (idx > 0 && ordered[idx-1] > s) idx--;
      ordered.insert(idx, s);
      if (arrivals.size() != span) return;
      low_n = (ordered.size() + 1) / 2;
      med = ordered[low_n-1];
      acc = 0;
      foreach (ordered[j]) acc += (ordered[j] > med) ? ordered[j] - med : med - ordered[j];
      if (acc > 64'hff_ffff_ffff) acc = 64'hff_ffff_ffff;
      res.median = med[31:0];
      res.cost   = acc[swmc_pkg::CostW-1:0];
      pending_results.push_back(res);
    endfunction

    function void compare_result(logic [71:0] data);
      median_cost_t got;
      median_cost_t want;
      got = data;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: median %0d cost %0d",
               $signed(got.median), got.cost);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.median !== want.median) begin
        $error("median: expected %0d, got %0d", $signed(want.median), $signed(got.median));
        errors++;
      end
      if (got.cost !== want.cost) begin
        $error("cost: expected %0d, got %0d", want.cost, got.cost);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [swmc_pkg::CountW-1:0] cfg_wdata_i;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  logic [31:0]                 s_axis_tdata;  // sample
  logic                        s_axis_tuser;  // first
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [71:0]                 m_axis_tdata;  // median, cost

  median_cost_scoreboard sb;
  int unsigned           cycle_count = 0;
  int unsigned           burst_left  = 0;
  int unsigned           rx_left     = 0;
  int unsigned           stall_left  = 0;
  rx_pattern_e           rx_pattern  = RX_READY;

  sliding_window_median_cost uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_median_cost verification failed");
      $finish;
    end
  end

  // result side: check, then pick the next ready level
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.compare_result(m_axis_tdata);
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_e'($urandom_range(0, 3));
      rx_left    = $urandom_range(40, 300);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_READY: begin
        m_axis_tready <= 1'b1;
      end
      RX_COIN: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      RX_LONG: begin
        if (stall_left != 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
          if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(5, 25);
        end
      end
      default: begin
        m_axis_tready <= (rx_left % 3 == 0);
      end
    endcase
  end

  task automatic send_item(input logic [31:0] value, input logic restart);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_sample(value, restart);
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [swmc_pkg::CountW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_window(value);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return S_MIN;
          1:       return S_MAX;
          2:       return 32'd0;
          default: return S_NEG1;
        endcase
      end
      1, 2, 3: return 32'($urandom_range(0, 15)) - 32'd8;
      4, 5:    return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  // {first, sample}; the first four run at the reset window of one
  localparam logic [32:0] DIRECTED [22] = '{
    {1'b0, S_MIN}, {1'b1, S_MAX}, {1'b0, 32'd0}, {1'b0, S_NEG1},
    {1'b0, S_MIN}, {1'b0, S_MAX}, {1'b0, S_MAX}, {1'b0, S_MAX},
    {1'b0, S_MIN}, {1'b0, S_MIN}, {1'b1, 32'd5}, {1'b0, 32'd5},
    {1'b0, 32'd5}, {1'b0, S_NEG1}, {1'b0, 32'd7}, {1'b1, 32'd7},
    {1'b0, 32'd0}, {1'b0, 32'hffff_fff8}, {1'b0, 32'd3}, {1'b1, 32'd1},
    {1'b0, 32'd2}, {1'b0, 32'd3}
  };

  logic [swmc_pkg::CountW-1:0] phase_window [10];
  int                          phase_items  [10];

  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    phase_window = '{9'd0, 9'd2, 9'd5, 9'd8, 9'd256, 9'd511,
                     9'($urandom_range(3, 40)), 9'($urandom_range(41, 255)),
                     9'd3, 9'd1};
    phase_items  = '{100, 150, 150, 150, 350, 300, 150, 150, 100, 50};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) begin
      if (i == 4) begin
        wait_drained();
        write_window(9'd3);
      end
      send_item(DIRECTED[i][31:0], DIRECTED[i][32]);
    end

    foreach (phase_window[p]) begin
      wait_drained();
      write_window(phase_window[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        logic restart;
        if (i == phase_items[p] / 2 && (p == 1 || $urandom_range(0, 2) == 0)) wait_drained();
        pace_sender();
        restart = (i == 0) ? ($urandom_range(0, 3) == 0)
                           : ($urandom_range(0, 15 * sb.span) == 0);
        send_item(pick_sample(), restart);
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("sliding_window_median_cost verification clean");
    end else begin
      $display("sliding_window_median_cost verification failed");
    end
    $finish;
  end

endmodule
